/* rtl/ljrc_pkg.sv */
// Package: shared types, codes and reset constants for the lift jam reverse controller.
package ljrc_pkg;

    localparam int TIMER_BITS_DEF = 16;

    localparam int STALL_W = 7;
    localparam int HOLD_W  = 16;
    localparam int COOL_W  = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam logic [STALL_W-1:0] STALL_SPEED_RST = 7'd20;
    localparam logic [HOLD_W-1:0]  JAM_HOLD_RST    = 16'd1000;
    localparam logic [COOL_W-1:0]  COOLDOWN_RST    = 16'd1500;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] REG_STALL_SPEED = 2'd0;
    localparam logic [IDX_W-1:0] REG_JAM_HOLD    = 2'd1;
    localparam logic [IDX_W-1:0] REG_COOLDOWN    = 2'd2;

    // drive command codes
    localparam logic [1:0] CMD_STOP = 2'd0;
    localparam logic [1:0] CMD_FWD  = 2'd1;
    localparam logic [1:0] CMD_REV  = 2'd2;

    typedef struct packed {
        logic [7:0]        elapsed_ms;
        logic              toggle_button;
        logic              reverse_button;
        logic signed [7:0] motor_speed;
    } ljrc_in_t;

    typedef struct packed {
        logic [1:0] motor_cmd;
        logic       run_on;
        logic       jam_active;
    } ljrc_out_t;

endpackage

/* rtl/lift_jam_reverse_controller.sv */
// Top level: lift motor controller with run toggle, manual reverse and jam auto-reverse.
//
// One input transfer is one control tick and yields exactly one result transfer.
// A tick lands in an input register, then a single pass of short logic (two
// saturating timer adds, a speed magnitude and a few compares) updates the state
// and loads the result register. Throughput is one tick per clock while m_ready
// is high; each tick moves from the input register into the result register,
// and the two form a two-deep pipe, so a new tick is taken while a finished result
// still waits for m_ready; back-pressure reaches s_ready only when both are full.
// Timers are TIMER_BITS wide and saturate at 2^TIMER_BITS - 1. The configuration
// registers (stall_speed, jam_hold_ms, cooldown_ms) are written through cfg_we,
// cfg_index and cfg_wdata; the user must write them only while the block is idle,
// which the block itself does not enforce. An index beyond the list is ignored.
// The drive command uses the jam flag from before this tick's detection, while
// jam_active reports the flag after detection and clearing.
module lift_jam_reverse_controller #(
    parameter int TIMER_BITS = ljrc_pkg::TIMER_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ljrc_pkg::ljrc_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ljrc_pkg::ljrc_out_t           m_data,
    input  logic                          cfg_we,
    input  logic [ljrc_pkg::IDX_W-1:0]    cfg_index,
    input  logic [ljrc_pkg::CFG_W-1:0]    cfg_wdata
);
    import ljrc_pkg::*;

    // compare width covers both the timers and the 16-bit thresholds
    localparam int CMP_W = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    // configuration
    logic [STALL_W-1:0] stall_speed_reg;
    logic [HOLD_W-1:0]  jam_hold_reg;
    logic [COOL_W-1:0]  cooldown_reg;

    // pipe registers
    logic      in_valid_reg;
    ljrc_in_t  in_data_reg;
    logic      out_valid_reg;
    ljrc_out_t out_data_reg;

    // controller state
    logic                  run_mode_reg, run_mode_next;
    logic                  button_held_reg, button_held_next;
    logic                  jam_flag_reg, jam_flag_next;
    logic [TIMER_BITS-1:0] jam_elapsed_reg, jam_elapsed_next;
    logic [TIMER_BITS-1:0] cool_elapsed_reg, cool_elapsed_next;
    ljrc_out_t             out_data_next;

    logic out_free;
    logic advance;

    // datapath intermediates
    logic [TIMER_BITS:0]   jam_sum;
    logic [TIMER_BITS:0]   cool_sum;
    logic [TIMER_BITS-1:0] jam_sat;
    logic [TIMER_BITS-1:0] cool_sat;
    logic [TIMER_BITS-1:0] cool_after_tog;
    logic [TIMER_BITS-1:0] jam_after_det;
    logic [7:0]            speed_mag;
    logic                  tog_rise;
    logic                  run_mid;
    logic                  jam_detect;
    logic                  jam_mid;
    logic                  jam_clear;

    // advance the input register into the result register when the result slot
    // is empty or its transfer happens this cycle
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_speed_reg <= STALL_SPEED_RST;
            jam_hold_reg    <= JAM_HOLD_RST;
            cooldown_reg    <= COOLDOWN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_STALL_SPEED: stall_speed_reg <= cfg_wdata[STALL_W-1:0];
                REG_JAM_HOLD:    jam_hold_reg    <= cfg_wdata[HOLD_W-1:0];
                REG_COOLDOWN:    cooldown_reg    <= cfg_wdata[COOL_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_comb begin
        // saturating timer adds
        jam_sum  = {1'b0, jam_elapsed_reg}
                 + {{(TIMER_BITS + 1 - 8){1'b0}}, in_data_reg.elapsed_ms};
        cool_sum = {1'b0, cool_elapsed_reg}
                 + {{(TIMER_BITS + 1 - 8){1'b0}}, in_data_reg.elapsed_ms};
        jam_sat  = jam_sum[TIMER_BITS]  ? TIMER_MAX : jam_sum[TIMER_BITS-1:0];
        cool_sat = cool_sum[TIMER_BITS] ? TIMER_MAX : cool_sum[TIMER_BITS-1:0];

        // |speed| in 8 bits unsigned; -128 maps to 128
        speed_mag = in_data_reg.motor_speed[7] ? (8'd0 - in_data_reg.motor_speed)
                                               : in_data_reg.motor_speed;

        // toggle press edge flips run mode and restarts the cooldown
        tog_rise         = in_data_reg.toggle_button && !button_held_reg;
        button_held_next = in_data_reg.toggle_button;
        run_mid          = tog_rise ? !run_mode_reg : run_mode_reg;
        cool_after_tog   = tog_rise ? '0 : cool_sat;

        // command uses the jam flag from before detection and clearing
        priority if (in_data_reg.reverse_button || jam_flag_reg) begin
            out_data_next.motor_cmd = CMD_REV;
        end else if (in_data_reg.toggle_button || run_mid) begin
            out_data_next.motor_cmd = CMD_FWD;
        end else begin
            out_data_next.motor_cmd = CMD_STOP;
        end

        // jam detection; the jam timer restarts only on a new jam
        jam_detect = run_mid
                  && ({1'b0, speed_mag} < {2'b0, stall_speed_reg})
                  && ({{(CMP_W - TIMER_BITS){1'b0}}, cool_after_tog}
                      > {{(CMP_W - COOL_W){1'b0}}, cooldown_reg});
        jam_mid       = jam_flag_reg || jam_detect;
        jam_after_det = (jam_detect && !jam_flag_reg) ? '0 : jam_sat;

        // jam clearing restarts the cooldown
        jam_clear = jam_mid
                 && ({{(CMP_W - TIMER_BITS){1'b0}}, jam_after_det}
                     > {{(CMP_W - HOLD_W){1'b0}}, jam_hold_reg})
                 && ({1'b0, speed_mag} > {2'b0, stall_speed_reg});

        run_mode_next     = run_mid;
        jam_flag_next     = jam_mid && !jam_clear;
        jam_elapsed_next  = jam_after_det;
        cool_elapsed_next = jam_clear ? '0 : cool_after_tog;

        out_data_next.run_on     = run_mid;
        out_data_next.jam_active = jam_flag_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            run_mode_reg     <= 1'b0;
            button_held_reg  <= 1'b0;
            jam_flag_reg     <= 1'b0;
            jam_elapsed_reg  <= '0;
            cool_elapsed_reg <= '0;
        end else begin
            // hold the input register until its tick moves on
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg    <= 1'b1;
                run_mode_reg     <= run_mode_next;
                button_held_reg  <= button_held_next;
                jam_flag_reg     <= jam_flag_next;
                jam_elapsed_reg  <= jam_elapsed_next;
                cool_elapsed_reg <= cool_elapsed_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    // a tick with the reverse button held always yields a reverse command
    a_manual_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_data_reg.reverse_button |=> m_data.motor_cmd == CMD_REV)
        else $error("manual reverse not honored");

    // a new jam starts with its hold timer at zero
    a_jam_timer_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(jam_flag_reg) |-> jam_elapsed_reg == '0)
        else $error("jam timer not restarted on new jam");

    // a stalled result freezes the controller state
    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> $stable(jam_flag_reg) && $stable(run_mode_reg)
            && $stable(cool_elapsed_reg))
        else $error("state moved while result stalled");

    // the result carries the state written with it
    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_data.jam_active == jam_flag_reg && m_data.run_on == run_mode_reg)
        else $error("result flags disagree with state");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the lift jam reverse controller: directed ticks, saturation and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ljrc_pkg::*;

    // Index past the end of the register list; the block must ignore writes to it.
    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    ljrc_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    ljrc_out_t        m_data;
    logic             cfg_we    = 1'b0;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    lift_jam_reverse_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the controller: configuration and tick-to-tick state.
    logic [STALL_W-1:0] stall_lvl;
    logic [HOLD_W-1:0]  hold_lvl;
    logic [COOL_W-1:0]  arm_lvl;
    logic               run_latch;
    logic               toggle_seen;
    logic               jam_seen;
    logic [15:0]        jam_ms;
    logic [15:0]        cool_ms;

    // Drive commands predicted for accepted ticks, oldest first.
    ljrc_out_t drive_queue[$];

    int unsigned wrong_count = 0;
    bit          idle_on     = 1'b1;  // clear to run both sides with no gaps
    int unsigned tog_left    = 0;     // ticks the random toggle press stays held
    int unsigned rev_left    = 0;     // ticks the random reverse press stays held

    function automatic logic [15:0] timer_sat_add(logic [15:0] t, logic [7:0] d);
        logic [16:0] s;
        s = {1'b0, t} + {9'd0, d};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    // Advance the shadow state by one tick and return the drive result it yields.
    function automatic ljrc_out_t predict_drive(ljrc_in_t t);
        logic [8:0] mag;
        ljrc_out_t  r;
        mag = t.motor_speed[7] ? (9'h100 - {1'b0, t.motor_speed}) : {1'b0, t.motor_speed};

        // Both timers advance first and stick at their maximum.
        jam_ms  = timer_sat_add(jam_ms, t.elapsed_ms);
        cool_ms = timer_sat_add(cool_ms, t.elapsed_ms);

        // Only the press edge of the toggle flips run mode and restarts the arming delay.
        if (t.toggle_button) begin
            if (!toggle_seen) begin
                run_latch = ~run_latch;
                cool_ms   = '0;
            end
            toggle_seen = 1'b1;
        end else begin
            toggle_seen = 1'b0;
        end

        // The command looks at the jam flag as it stood before this tick.
        if (t.reverse_button || jam_seen) begin
            r.motor_cmd = CMD_REV;
        end else if (t.toggle_button || run_latch) begin
            r.motor_cmd = CMD_FWD;
        end else begin
            r.motor_cmd = CMD_STOP;
        end

        // Declare a jam; the hold timer restarts only on a fresh jam.
        if (run_latch && mag < {2'b0, stall_lvl} && cool_ms > arm_lvl) begin
            if (!jam_seen) jam_ms = '0;
            jam_seen = 1'b1;
        end

        // Clear the jam once held long enough and the motor spins again.
        if (jam_seen && jam_ms > hold_lvl && mag > {2'b0, stall_lvl}) begin
            cool_ms  = '0;
            jam_seen = 1'b0;
        end

        r.run_on     = run_latch;
        r.jam_active = jam_seen;
        return r;
    endfunction

    task automatic flag_wrong(string what, int got, int want);
        if (wrong_count < 40) begin
            $display("[%0t] %s: got %0d, want %0d", $realtime, what, got, want);
        end
        wrong_count++;
    endtask

    // Compare each result transfer against the oldest pending prediction.
    always @(posedge aclk) begin
        ljrc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_queue.size() == 0) begin
                flag_wrong("result with nothing pending", m_data, 0);
            end else begin
                want = drive_queue.pop_front();
                if (m_data.motor_cmd !== want.motor_cmd)
                    flag_wrong("motor_cmd wrong", m_data.motor_cmd, want.motor_cmd);
                if (m_data.run_on !== want.run_on)
                    flag_wrong("run_on wrong", m_data.run_on, want.run_on);
                if (m_data.jam_active !== want.jam_active)
                    flag_wrong("jam_active wrong", m_data.jam_active, want.jam_active);
            end
        end
    end

    // Stall the result side about a quarter of the time, unless idling is off.
    always @(posedge aclk) begin
        if (idle_on && $urandom_range(99) < 25) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Send one tick: maybe idle first, then hold valid until the transfer happens.
    task automatic send_tick(ljrc_in_t t);
        if (idle_on && $urandom_range(99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        drive_queue.push_back(predict_drive(t));
    endtask

    // Drop valid and wait for every pending result, then let the pipe settle.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (drive_queue.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register; the block must be idle.
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_STALL_SPEED: stall_lvl = data[STALL_W-1:0];
            REG_JAM_HOLD:    hold_lvl  = data[HOLD_W-1:0];
            REG_COOLDOWN:    arm_lvl   = data[COOL_W-1:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_regs(logic [CFG_W-1:0] stall, logic [CFG_W-1:0] hold,
                            logic [CFG_W-1:0] cool);
        wait_all_results();
        write_reg(REG_STALL_SPEED, stall);
        write_reg(REG_JAM_HOLD, hold);
        write_reg(REG_COOLDOWN, cool);
    endtask

    // Speeds clustered around the stall level, with some raw 8-bit noise.
    function automatic logic [7:0] pick_speed();
        int unsigned r;
        int unsigned m;
        r = $urandom_range(99);
        if (r < 35) begin
            m = (stall_lvl == 0) ? 0 : $urandom_range(stall_lvl - 1);
        end else if (r < 45) begin
            m = stall_lvl + $urandom_range(1);
        end else if (r < 90) begin
            m = $urandom_range(127, (stall_lvl < 127) ? stall_lvl + 1 : 127);
        end else begin
            return 8'($urandom_range(255));
        end
        return ($urandom_range(1) != 0) ? 8'(-m) : 8'(m);
    endfunction

    // Random ticks with button presses held over a few ticks, as a person would.
    task automatic run_random_ticks(int unsigned n);
        ljrc_in_t    t;
        int unsigned r;
        repeat (n) begin
            r = $urandom_range(99);
            t.elapsed_ms = (r < 10) ? 8'd0 : (r < 20) ? 8'd255 : 8'($urandom_range(255));
            if (tog_left == 0 && $urandom_range(99) < 4) tog_left = $urandom_range(4, 1);
            t.toggle_button = (tog_left != 0);
            if (tog_left != 0) tog_left--;
            if (rev_left == 0 && $urandom_range(99) < 3) rev_left = $urandom_range(6, 1);
            t.reverse_button = (rev_left != 0);
            if (rev_left != 0) rev_left--;
            t.motor_speed = pick_speed();
            send_tick(t);
            // Now and then hold the sender until the pipe has drained completely.
            if ($urandom_range(149) == 0) wait_all_results();
        end
    endtask

    // Walk through start, stall, jam, recovery and manual reverse at reset settings.
    task automatic test_directed_ticks();
        send_tick('{8'd0,   1'b0, 1'b0, 8'h00});  // idle: stop
        send_tick('{8'd255, 1'b0, 1'b1, 8'h00});  // manual reverse with run off
        send_tick('{8'd10,  1'b1, 1'b0, 8'h64});  // press toggle: run on
        send_tick('{8'd10,  1'b1, 1'b0, 8'h64});  // still held: no second flip
        send_tick('{8'd0,   1'b0, 1'b0, 8'h7F});  // speed above range
        send_tick('{8'd255, 1'b0, 1'b0, 8'h80});  // -128 counts as 128
        repeat (6) send_tick('{8'd255, 1'b0, 1'b0, 8'h00});  // arm and declare jam
        send_tick('{8'd255, 1'b0, 1'b0, 8'h14});  // speed at stall level: no clear
        repeat (4) send_tick('{8'd255, 1'b0, 1'b0, 8'hEB});  // -21 clears after hold
        send_tick('{8'd0,   1'b0, 1'b1, 8'h32});  // manual reverse while running
        send_tick('{8'd100, 1'b1, 1'b0, 8'h32});  // press: run off, forward while held
        send_tick('{8'd100, 1'b1, 1'b1, 8'h32});  // reverse wins over held toggle
        send_tick('{8'd0,   1'b0, 1'b0, 8'h9C});  // -100, stop
        send_tick('{8'd255, 1'b0, 1'b0, 8'h64});
        wait_all_results();
    endtask

    // Push both timers to their maximum; a threshold at the maximum is never exceeded.
    task automatic test_timer_saturation();
        idle_on = 1'b0;
        set_regs(16'd20, 16'hFFFF, 16'hFFFF);
        if (!run_latch) send_tick('{8'd10, 1'b1, 1'b0, 8'h64});
        repeat (270) send_tick('{8'd255, 1'b0, 1'b0, 8'h00});  // never arms
        wait_all_results();
        write_reg(REG_COOLDOWN, 16'hFFFE);
        send_tick('{8'd255, 1'b0, 1'b0, 8'h00});               // jam now declared
        repeat (270) send_tick('{8'd255, 1'b0, 1'b0, 8'h64});  // hold never expires
        wait_all_results();
        write_reg(REG_JAM_HOLD, 16'hFFFE);
        send_tick('{8'd0, 1'b0, 1'b0, 8'h64});                 // saturated timer clears it
        idle_on = 1'b1;
        set_regs(STALL_SPEED_RST, JAM_HOLD_RST, COOLDOWN_RST);
    endtask

    // Random traffic under a series of register settings, extremes included.
    task automatic test_register_settings();
        run_random_ticks(250);
        set_regs(16'hFF80, 16'h0000, 16'h0000);  // upper bits masked: stall level 0
        run_random_ticks(150);
        set_regs(16'h007F, 16'hFFFF, 16'h0000);
        run_random_ticks(100);
        set_regs(16'd100, 16'd300, 16'd400);
        idle_on = 1'b0;
        run_random_ticks(200);
        idle_on = 1'b1;
        repeat (3) begin
            set_regs(16'($urandom), 16'($urandom_range(1500)), 16'($urandom_range(2000)));
            run_random_ticks(180);
        end
    endtask

    // A write past the register list must leave every setting alone.
    task automatic test_ignored_index();
        wait_all_results();
        write_reg(REG_NONE, 16'($urandom) | 16'hA5A5);
        write_reg(REG_NONE, 16'h0000);
        run_random_ticks(100);
    endtask

    initial begin
        stall_lvl   = STALL_SPEED_RST;
        hold_lvl    = JAM_HOLD_RST;
        arm_lvl     = COOLDOWN_RST;
        run_latch   = 1'b0;
        toggle_seen = 1'b0;
        jam_seen    = 1'b0;
        jam_ms      = '0;
        cool_ms     = '0;

        // Hold reset, then release it for good.
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_ticks();
        test_timer_saturation();
        test_register_settings();
        test_ignored_index();

        wait_all_results();
        repeat (8) @(posedge aclk);
        if (wrong_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Stop a hung run well past the slowest legal finish.
    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ljrc_pkg.sv
rtl/lift_jam_reverse_controller.sv
tb/sv/tb.sv
